// File: rtl/vas_pkg.sv
package vas_pkg;

  localparam int VOICES_DEFAULT = 16;

  localparam int CMD_W = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int AGE_W = 32;
  localparam int REL_W = 16;
  localparam int IDX_OUT_W = 4;
  localparam int ACT_W = 3;
  localparam int CNT_OUT_W = 5;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam logic [CFG_AW-1:0] REG_MONO_MODE = 1'd0;
  localparam logic [CFG_AW-1:0] REG_RELEASE_SAMPLES = 1'd1;

  localparam logic [REL_W-1:0] RELEASE_RESET = 16'd441;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START_FREE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START_STOLEN = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LEGATO = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASED = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ALL_RELEASED = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TICK = 3'd6;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PLAYING = 2'd1;
  localparam logic [1:0] MODE_RELEASING = 2'd2;

  typedef struct packed {
    logic load_in;
    logic search_step;
    logic apply;
    logic count_step;
    logic load_out;
  } vas_cmd_t;

  typedef struct packed {
    logic scan_last;
  } vas_stat_t;

endpackage

// File: rtl/vas_ctrl.sv
module vas_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output vas_pkg::vas_cmd_t  cmd,
  input  vas_pkg::vas_stat_t stat
);
  import vas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_COUNT,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load_in = (state == S_IDLE) && in_valid;
    cmd.search_step = (state == S_SEARCH);
    cmd.apply = (state == S_APPLY);
    cmd.count_step = (state == S_COUNT);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat.scan_last) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_COUNT;
        end
        S_COUNT: begin
          if (stat.scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/vas_dp.sv
module vas_dp #(
  parameter int VOICES = vas_pkg::VOICES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  vas_pkg::vas_cmd_t                cmd,
  output vas_pkg::vas_stat_t               stat,
  input  logic                             cfg_we,
  input  logic [vas_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [vas_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic [vas_pkg::CMD_W-1:0]        in_cmd,
  input  logic [vas_pkg::NOTE_W-1:0]       in_note,
  input  logic [vas_pkg::VEL_W-1:0]        in_velocity,
  output logic [vas_pkg::IDX_OUT_W-1:0]    voice_index,
  output logic [vas_pkg::ACT_W-1:0]        action,
  output logic [vas_pkg::VEL_W-1:0]        voice_velocity,
  output logic [vas_pkg::CNT_OUT_W-1:0]    active_voices,
  output logic [vas_pkg::CNT_OUT_W-1:0]    voices_idled
);
  import vas_pkg::*;

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  logic             mono_mode;
  logic [REL_W-1:0] release_samples;

  logic [CMD_W-1:0]  cmd_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;

  logic [1:0]        mode [VOICES];
  logic [NOTE_W-1:0] note [VOICES];
  logic [VEL_W-1:0]  vel [VOICES];
  logic [AGE_W-1:0]  age [VOICES];
  logic [REL_W-1:0]  rel [VOICES];
  logic              idled [VOICES];

  logic [IW-1:0]    scan_idx;
  logic             idle_found;
  logic [IW-1:0]    idle_idx;
  logic             match_found;
  logic [IW-1:0]    match_idx;
  logic [VEL_W-1:0] match_vel;
  logic [IW-1:0]    old_idx;
  logic [AGE_W-1:0] old_age;
  logic [CW-1:0]    cnt_act;
  logic [CW-1:0]    cnt_idl;

  logic [IW-1:0]    res_idx;
  logic [ACT_W-1:0] res_act;
  logic [VEL_W-1:0] res_vel;

  logic [1:0]        rd_mode;
  logic [NOTE_W-1:0] rd_note;
  logic [VEL_W-1:0]  rd_vel;
  logic [AGE_W-1:0]  rd_age;
  logic              rd_idled;

  logic             on_en;
  logic             off_en;
  logic [IW-1:0]    tgt;
  logic [ACT_W-1:0] ap_act;
  logic [VEL_W-1:0] ap_vel;

  logic [IW+IDX_OUT_W-1:0] idx_wide;
  logic [CW+CNT_OUT_W-1:0] act_wide;
  logic [CW+CNT_OUT_W-1:0] idl_wide;

  assign stat.scan_last = (scan_idx == IW'(VOICES - 1));

  assign rd_mode = mode[scan_idx];
  assign rd_note = note[scan_idx];
  assign rd_vel = vel[scan_idx];
  assign rd_age = age[scan_idx];
  assign rd_idled = idled[scan_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode <= 1'b0;
      release_samples <= RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MONO_MODE: mono_mode <= cfg_wdata[0];
        REG_RELEASE_SAMPLES: release_samples <= cfg_wdata[REL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_cmd;
      note_r <= in_note;
      vel_r <= in_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.load_in) begin
      scan_idx <= '0;
    end else if (cmd.search_step || cmd.count_step) begin
      scan_idx <= stat.scan_last ? '0 : scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idle_found <= 1'b0;
      idle_idx <= '0;
      match_found <= 1'b0;
      match_idx <= '0;
      match_vel <= '0;
      old_idx <= '0;
      old_age <= '0;
      cnt_act <= '0;
      cnt_idl <= '0;
    end else begin
      if (cmd.search_step) begin
        if (rd_mode == MODE_IDLE && !idle_found) begin
          idle_found <= 1'b1;
          idle_idx <= scan_idx;
        end
        if (rd_mode == MODE_PLAYING && rd_note == note_r && !match_found) begin
          match_found <= 1'b1;
          match_idx <= scan_idx;
          match_vel <= rd_vel;
        end
        if (rd_age > old_age) begin
          old_idx <= scan_idx;
          old_age <= rd_age;
        end
      end
      if (cmd.count_step) begin
        cnt_act <= cnt_act + CW'(rd_mode != MODE_IDLE);
        cnt_idl <= cnt_idl + CW'(rd_idled);
      end
    end
  end

  always_comb begin
    on_en = 1'b0;
    off_en = 1'b0;
    tgt = '0;
    ap_act = ACT_NONE;
    ap_vel = '0;
    case (cmd_r)
      CMD_TICK: begin
        ap_act = ACT_TICK;
      end
      CMD_NOTE_ON: begin
        on_en = 1'b1;
        ap_vel = vel_r;
        if (mono_mode) begin
          ap_act = (mode[0] == MODE_PLAYING) ? ACT_LEGATO : ACT_START_FREE;
        end else if (idle_found) begin
          tgt = idle_idx;
          ap_act = ACT_START_FREE;
        end else begin
          tgt = old_idx;
          ap_act = ACT_START_STOLEN;
        end
      end
      CMD_NOTE_OFF: begin
        if (mono_mode) begin
          if (mode[0] == MODE_PLAYING) begin
            off_en = 1'b1;
            ap_act = ACT_RELEASED;
            ap_vel = vel[0];
          end
        end else if (match_found) begin
          off_en = 1'b1;
          tgt = match_idx;
          ap_act = ACT_RELEASED;
          ap_vel = match_vel;
        end
      end
      CMD_ALL_OFF: begin
        ap_act = ACT_ALL_RELEASED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_idx <= tgt;
      res_act <= ap_act;
      res_vel <= ap_vel;
    end
  end

  for (genvar i = 0; i < VOICES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        mode[i] <= MODE_IDLE;
        idled[i] <= 1'b0;
      end else if (cmd.apply) begin
        idled[i] <= 1'b0;
        case (cmd_r)
          CMD_TICK: begin
            if (mode[i] != MODE_IDLE) begin
              if (age[i] != '1) begin
                age[i] <= age[i] + 1'b1;
              end
              if (mode[i] == MODE_RELEASING) begin
                if (rel[i] <= REL_W'(1)) begin
                  rel[i] <= '0;
                  mode[i] <= MODE_IDLE;
                  idled[i] <= 1'b1;
                end else begin
                  rel[i] <= rel[i] - 1'b1;
                end
              end
            end
          end
          CMD_NOTE_ON: begin
            if (on_en && tgt == IW'(i)) begin
              mode[i] <= MODE_PLAYING;
              note[i] <= note_r;
              vel[i] <= vel_r;
              age[i] <= '0;
              rel[i] <= '0;
            end
          end
          CMD_NOTE_OFF: begin
            if (off_en && tgt == IW'(i)) begin
              mode[i] <= MODE_RELEASING;
              rel[i] <= release_samples;
            end
          end
          CMD_ALL_OFF: begin
            if (mode[i] == MODE_PLAYING) begin
              mode[i] <= MODE_RELEASING;
              rel[i] <= release_samples;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign idx_wide = (IW + IDX_OUT_W)'(res_idx);
  assign act_wide = (CW + CNT_OUT_W)'(cnt_act);
  assign idl_wide = (CW + CNT_OUT_W)'(cnt_idl);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      voice_index <= idx_wide[IDX_OUT_W-1:0];
      action <= res_act;
      voice_velocity <= res_vel;
      active_voices <= act_wide[CNT_OUT_W-1:0];
      voices_idled <= idl_wide[CNT_OUT_W-1:0];
    end
  end

endmodule

// File: rtl/voice_allocator_oldest_steal.sv
// Each input beat takes two passes over the voice registers through one shared scan
// port: a search pass before the update and a counting pass after it. A new input beat
// is taken only once the previous result has been loaded into the output register.
// Reset (rst, synchronous): all voices idle, mono_mode 0, release_samples 441,
// no result pending.
module voice_allocator_oldest_steal #(
  parameter int VOICES = vas_pkg::VOICES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vas_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [vas_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // note[6:0], velocity[13:7], zero fill [15:14]
  input  logic [vas_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [vas_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // voice_index[3:0], voice_velocity[10:4], active_voices[15:11],
  // voices_idled[20:16], zero fill [23:21]
  output logic [vas_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // action[2:0]
  output logic [vas_pkg::ACT_W-1:0]      m_axis_tuser
);
  import vas_pkg::*;

  vas_cmd_t  cmd;
  vas_stat_t stat;

  logic [IDX_OUT_W-1:0] voice_index;
  logic [VEL_W-1:0]     voice_velocity;
  logic [CNT_OUT_W-1:0] active_voices;
  logic [CNT_OUT_W-1:0] voices_idled;

  vas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vas_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (s_axis_tuser),
    .in_note        (s_axis_tdata[NOTE_W-1:0]),
    .in_velocity    (s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W]),
    .voice_index    (voice_index),
    .action         (m_axis_tuser),
    .voice_velocity (voice_velocity),
    .active_voices  (active_voices),
    .voices_idled   (voices_idled)
  );

  assign m_axis_tdata = {3'b000, voices_idled, active_voices, voice_velocity, voice_index};

`ifndef SYNTHESIS
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result beat rose right after an input beat");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 3'd7)
    else $error("undefined action code on result beat");

  a_tick_no_voice: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_TICK || m_axis_tuser == ACT_ALL_RELEASED)
      |-> m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[10:4] == 7'd0)
    else $error("tick or all-off beat carries a voice");

  a_idled_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ACT_TICK |-> m_axis_tdata[20:16] == 5'd0)
    else $error("voices idled outside a tick");
`endif

endmodule
